// ===== design/fpls_pkg.sv =====
`timescale 1ns / 1ps
// Package for the farthest point landmark selection block.
// Shared widths, default sizes and register indexes; no dependencies.
package fpls_pkg;
  localparam int DefMaxPoints    = 1024;
  localparam int DefMaxDim       = 8;
  localparam int DefMaxLandmarks = 64;

  localparam int CoordW = 16;
  localparam int DistW  = 35;
  localparam int IdxW   = 10;
  localparam int RankW  = 6;
  localparam int CntW   = 7;
  localparam int CfgAW  = 3;
  localparam int CfgDW  = 11;

  localparam logic [DistW-1:0] DistMax = '1;

  typedef enum logic [CfgAW-1:0] {
    REG_POINT_COUNT    = 3'd0,
    REG_DIMENSIONS     = 3'd1,
    REG_LANDMARK_COUNT = 3'd2,
    REG_FIRST_LANDMARK = 3'd3
  } cfg_reg_e;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_RUN  = 1'b1;
endpackage

// ===== design/fpls_ram.sv =====
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module fpls_ram #(
  parameter int Width = 16,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule

// ===== design/farthest_point_landmark_selection_top.sv =====
`timescale 1ns / 1ps
// Farthest point landmark selection. Load request: no result. Run request: first result
// in the cycle after accept; each later round reads the current landmark, scans every
// point on every axis and drains, at one coordinate read and one multiply per cycle.
// busy_o stays high until the final result is driven; a one-landmark run never raises it.
// Results cannot be stalled by the receiver.
// Reset clears control and config; coordinate memory is undefined until loaded.
module farthest_point_landmark_selection_top
  import fpls_pkg::*;
#(
  parameter int MAX_POINTS    = DefMaxPoints,
  parameter int MAX_DIM       = DefMaxDim,
  parameter int MAX_LANDMARKS = DefMaxLandmarks
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  logic              opcode_i,
  input  logic [IdxW-1:0]   point_index_i,
  input  logic [2:0]        axis_index_i,
  input  logic signed [CoordW-1:0] coordinate_i,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [CfgAW-1:0]  cfg_addr_i,
  input  logic [CfgDW-1:0]  cfg_data_i,
  output logic              result_valid_o,
  output logic [IdxW-1:0]   landmark_index_o,
  output logic [RankW-1:0]  rank_o,
  output logic [DistW-1:0]  min_distance_sq_o,
  output logic              last_o
);
  localparam int PW = $clog2(MAX_POINTS);
  localparam int AW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int CoordDepth = MAX_POINTS * (2 ** AW);
  localparam int NearW = DistW + 1;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CUR   = 3'd1;
  localparam logic [2:0] ST_SCAN  = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;
  localparam logic [2:0] ST_FIN   = 3'd4;

  logic [2:0] state_q, state_d;

  logic [10:0] pc_q;
  logic [3:0]  dim_q;
  logic [6:0]  lc_q;
  logic [9:0]  fl_q;

  logic [PW-1:0]   nm1_q, cur_idx_q, j_q, best_q;
  logic [AW-1:0]   dm1_q, a_q;
  logic [CntW-1:0] count_q;
  logic [RankW-1:0] round_q;
  logic            first_round_q, best_found_q;
  logic [DistW-1:0] best_d_q;

  logic            s1_v_q, s1_cur_q, s1_first_q, s1_last_q;
  logic [AW-1:0]   s1_a_q;
  logic [PW-1:0]   s1_j_q;
  logic            s2_v_q, s2_first_q, s2_last_q;
  logic [PW-1:0]   s2_j_q;
  logic            s3_v_q, s3_first_q, s3_last_q;
  logic [PW-1:0]   s3_j_q;
  logic            s4_v_q;
  logic [PW-1:0]   s4_j_q;

  logic signed [CoordW-1:0] cur_q [MAX_DIM];
  logic signed [CoordW:0]   diff_q;
  logic [33:0]              sq_q;
  logic [DistW-1:0]         acc_q;
  logic [NearW-1:0]         near2_q, near3_q, near4_q;

  logic                  res_v_q, res_last_q;
  logic [IdxW-1:0]       res_idx_q;
  logic [RankW-1:0]      res_rank_q;
  logic [DistW-1:0]      res_dist_q;

  logic                  accept, run_go, load_go;
  logic                  c_we, n_we;
  logic [$clog2(CoordDepth)-1:0] c_waddr, c_raddr;
  logic [CoordW-1:0]     c_rdata;
  logic [PW-1:0]         n_waddr;
  logic [NearW-1:0]      n_wdata, n_rdata;
  logic                  issue_v, issue_cur;
  logic                  s4_chosen, s4_better;
  logic [DistW-1:0]      s4_old, s4_new;
  logic [DistW:0]        acc_sum;
  logic                  fin_last;
  logic [31:0]           n_int, d_int, c_int, f_int;

  assign accept  = start_i && !busy_o;
  assign run_go  = accept && (opcode_i == OP_RUN);
  assign load_go = accept && (opcode_i == OP_LOAD) &&
                   (32'(point_index_i) < MAX_POINTS) && (32'(axis_index_i) < MAX_DIM);
  assign busy_o      = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;

  // effective run settings
  always_comb begin
    n_int = (pc_q == '0) ? 32'd1 : 32'(pc_q);
    if (n_int > MAX_POINTS) n_int = MAX_POINTS;
    d_int = (dim_q == '0) ? 32'd1 : 32'(dim_q);
    if (d_int > MAX_DIM) d_int = MAX_DIM;
    c_int = (lc_q == '0) ? 32'd1 : 32'(lc_q);
    if (c_int > MAX_LANDMARKS) c_int = MAX_LANDMARKS;
    if (c_int > n_int) c_int = n_int;
    f_int = 32'(fl_q);
    if (f_int >= n_int) f_int = n_int - 32'd1;
  end

  assign issue_v   = (state_q == ST_CUR) || (state_q == ST_SCAN);
  assign issue_cur = (state_q == ST_CUR);

  assign c_we    = load_go;
  assign c_waddr = {PW'(point_index_i), AW'(axis_index_i)};
  assign c_raddr = issue_cur ? {cur_idx_q, a_q} : {j_q, a_q};

  fpls_ram #(.Width(CoordW), .Depth(CoordDepth)) u_coord_ram (
    .clk_i   (clk_i),
    .we_i    (c_we),
    .waddr_i (c_waddr),
    .wdata_i (coordinate_i),
    .raddr_i (c_raddr),
    .rdata_o (c_rdata)
  );

  assign s4_chosen = first_round_q ? (s4_j_q == cur_idx_q) : near4_q[DistW];
  assign s4_old    = first_round_q ? DistMax : near4_q[DistW-1:0];
  assign s4_new    = (acc_q < s4_old) ? acc_q : s4_old;
  assign s4_better = s4_v_q && !s4_chosen && (!best_found_q || (s4_new > best_d_q));

  assign n_we    = s4_v_q || (state_q == ST_FIN);
  assign n_waddr = (state_q == ST_FIN) ? best_q : s4_j_q;
  assign n_wdata = (state_q == ST_FIN) ? {1'b1, best_d_q} : {s4_chosen, s4_new};

  fpls_ram #(.Width(NearW), .Depth(MAX_POINTS)) u_near_ram (
    .clk_i   (clk_i),
    .we_i    (n_we),
    .waddr_i (n_waddr),
    .wdata_i (n_wdata),
    .raddr_i (j_q),
    .rdata_o (n_rdata)
  );

  assign acc_sum  = {1'b0, acc_q} + {{(DistW-33){1'b0}}, sq_q};
  assign fin_last = (({1'b0, round_q} + CntW'(1)) == count_q);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (run_go && (c_int != 32'd1)) state_d = ST_CUR;
      end
      ST_CUR: begin
        if (a_q == dm1_q) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if ((a_q == dm1_q) && (j_q == nm1_q)) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!(s1_v_q || s2_v_q || s3_v_q || s4_v_q)) state_d = ST_FIN;
      end
      ST_FIN: begin
        state_d = fin_last ? ST_IDLE : ST_CUR;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pc_q <= 11'd1;
      dim_q <= 4'd1;
      lc_q <= 7'd1;
      fl_q <= '0;
      nm1_q <= '0;
      dm1_q <= '0;
      count_q <= '0;
      cur_idx_q <= '0;
      round_q <= '0;
      first_round_q <= 1'b0;
      best_found_q <= 1'b0;
      best_q <= '0;
      best_d_q <= '0;
      a_q <= '0;
      j_q <= '0;
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      s4_v_q <= 1'b0;
      res_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      res_v_q <= 1'b0;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_addr_i)
          REG_POINT_COUNT:    pc_q  <= cfg_data_i;
          REG_DIMENSIONS:     dim_q <= cfg_data_i[3:0];
          REG_LANDMARK_COUNT: lc_q  <= cfg_data_i[6:0];
          REG_FIRST_LANDMARK: fl_q  <= cfg_data_i[9:0];
          default: ;
        endcase
      end
      s1_v_q <= issue_v;
      s2_v_q <= s1_v_q && !s1_cur_q;
      s3_v_q <= s2_v_q;
      s4_v_q <= s3_v_q && s3_last_q;
      if (s4_better) begin
        best_found_q <= 1'b1;
        best_d_q <= s4_new;
        best_q <= s4_j_q;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (run_go) begin
            nm1_q <= PW'(n_int - 32'd1);
            dm1_q <= AW'(d_int - 32'd1);
            count_q <= CntW'(c_int);
            cur_idx_q <= PW'(f_int);
            round_q <= RankW'(1);
            first_round_q <= 1'b1;
            best_found_q <= 1'b0;
            a_q <= '0;
            res_v_q <= 1'b1;
          end
        end
        ST_CUR: begin
          if (a_q == dm1_q) begin
            a_q <= '0;
            j_q <= '0;
          end else begin
            a_q <= a_q + AW'(1);
          end
        end
        ST_SCAN: begin
          if (a_q == dm1_q) begin
            a_q <= '0;
            j_q <= j_q + PW'(1);
          end else begin
            a_q <= a_q + AW'(1);
          end
        end
        ST_DRAIN: ;
        ST_FIN: begin
          res_v_q <= 1'b1;
          cur_idx_q <= best_q;
          round_q <= round_q + RankW'(1);
          first_round_q <= 1'b0;
          best_found_q <= 1'b0;
          a_q <= '0;
        end
        default: ;
      endcase
    end
  end

  // datapath and result payload
  always_ff @(posedge clk_i) begin
    s1_cur_q   <= issue_cur;
    s1_a_q     <= a_q;
    s1_j_q     <= j_q;
    s1_first_q <= (a_q == '0);
    s1_last_q  <= (a_q == dm1_q);
    if (s1_v_q && s1_cur_q) begin
      cur_q[s1_a_q] <= c_rdata;
    end
    diff_q     <= {c_rdata[CoordW-1], c_rdata} - {cur_q[s1_a_q][CoordW-1], cur_q[s1_a_q]};
    near2_q    <= n_rdata;
    s2_j_q     <= s1_j_q;
    s2_first_q <= s1_first_q;
    s2_last_q  <= s1_last_q;
    sq_q       <= $unsigned(34'(diff_q) * 34'(diff_q));
    near3_q    <= near2_q;
    s3_j_q     <= s2_j_q;
    s3_first_q <= s2_first_q;
    s3_last_q  <= s2_last_q;
    if (s3_v_q) begin
      if (s3_first_q) acc_q <= {{(DistW-34){1'b0}}, sq_q};
      else acc_q <= acc_sum[DistW] ? DistMax : acc_sum[DistW-1:0];
    end
    near4_q    <= near3_q;
    s4_j_q     <= s3_j_q;
    if (state_q == ST_IDLE) begin
      res_idx_q  <= IdxW'(f_int);
      res_rank_q <= '0;
      res_dist_q <= '0;
      res_last_q <= (c_int == 32'd1);
    end else begin
      res_idx_q  <= IdxW'(best_q);
      res_rank_q <= round_q;
      res_dist_q <= best_d_q;
      res_last_q <= fin_last;
    end
  end

  assign result_valid_o    = res_v_q;
  assign landmark_index_o  = res_idx_q;
  assign rank_o            = res_rank_q;
  assign min_distance_sq_o = res_dist_q;
  assign last_o            = res_last_q;

  a_last_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && last_o |-> !busy_o)
    else $error("busy after final landmark");

  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !(s1_v_q || s2_v_q || s3_v_q || s4_v_q))
    else $error("pipeline active while idle");

  a_rank0_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && (rank_o == '0) |-> (min_distance_sq_o == '0))
    else $error("first landmark distance not zero");

  a_fin_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN) |-> !n_we || !s4_v_q)
    else $error("write port conflict");
endmodule

// ===== test/tb_farthest_point_landmark_selection_top.sv =====
`timescale 1ns / 1ps
// Testbench for farthest_point_landmark_selection_top: preload, directed table,
// then random load/run phases, each result checked against an in-bench max-min
// sampler. Depends on fpls_pkg, fpls_ram and the top-level RTL only.
module tb_farthest_point_landmark_selection_top;
  import fpls_pkg::*;

  typedef struct packed {
    logic [IdxW-1:0]  idx;
    logic [RankW-1:0] rank;
    logic [DistW-1:0] dist_sq;
    logic             last;
  } landmark_t;

  typedef enum logic [1:0] {ROW_CFG, ROW_LOAD, ROW_RUN} row_kind_e;

  typedef struct packed {
    row_kind_e        kind;
    logic [10:0]      target;
    logic [2:0]       axis;
    logic [15:0]      value;
    logic             typed;
    landmark_t        exp;
  } dir_row_t;

  // points 0..FullPts-1 loaded on every axis, up to AxisZeroPts-1 on axis 0 only
  localparam int FullPts     = 24;
  localparam int AxisZeroPts = 72;

  localparam int NumRows = 27;
  localparam landmark_t NoExp = '0;
  localparam landmark_t SoleFirst = '{idx: 10'd0, rank: 6'd0, dist_sq: '0, last: 1'b1};
  localparam landmark_t SoleLastPt = '{idx: 10'd3, rank: 6'd0, dist_sq: '0, last: 1'b1};
  localparam landmark_t SoleTopPt = '{idx: 10'd1023, rank: 6'd0, dist_sq: '0, last: 1'b1};

  dir_row_t dir_rows [NumRows] = '{
    '{ROW_RUN,  11'd0,                 3'd0, 16'h0000, 1'b1, SoleFirst},
    '{ROW_LOAD, 11'd0,                 3'd0, 16'h8000, 1'b0, NoExp},
    '{ROW_LOAD, 11'd1,                 3'd0, 16'h7FFF, 1'b0, NoExp},
    '{ROW_CFG,  11'(REG_POINT_COUNT),  3'd0, 16'd2,    1'b0, NoExp},
    '{ROW_CFG,  11'(REG_LANDMARK_COUNT), 3'd0, 16'd2,  1'b0, NoExp},
    '{ROW_RUN,  11'd0,                 3'd0, 16'h0000, 1'b0, NoExp},
    '{ROW_CFG,  11'(REG_DIMENSIONS),   3'd0, 16'd8,    1'b0, NoExp},
    '{ROW_LOAD, 11'd0,                 3'd7, 16'h8000, 1'b0, NoExp},
    '{ROW_LOAD, 11'd1,                 3'd7, 16'h7FFF, 1'b0, NoExp},
    '{ROW_LOAD, 11'd0,                 3'd3, 16'h8000, 1'b0, NoExp},
    '{ROW_LOAD, 11'd1,                 3'd3, 16'h7FFF, 1'b0, NoExp},
    '{ROW_RUN,  11'd0,                 3'd0, 16'hFFFF, 1'b0, NoExp},
    '{ROW_CFG,  11'(REG_POINT_COUNT),  3'd0, 16'd0,    1'b0, NoExp},
    '{ROW_RUN,  11'd0,                 3'd0, 16'h0000, 1'b1, SoleFirst},
    '{ROW_CFG,  11'(REG_POINT_COUNT),  3'd0, 16'd4,    1'b0, NoExp},
    '{ROW_CFG,  11'(REG_FIRST_LANDMARK), 3'd0, 16'd1000, 1'b0, NoExp},
    '{ROW_CFG,  11'(REG_LANDMARK_COUNT), 3'd0, 16'd0,  1'b0, NoExp},
    '{ROW_RUN,  11'd0,                 3'd0, 16'h0000, 1'b1, SoleLastPt},
    '{ROW_CFG,  11'd5,                 3'd0, 16'h07FF, 1'b0, NoExp},
    '{ROW_CFG,  11'(REG_POINT_COUNT),  3'd0, 16'h07FF, 1'b0, NoExp},
    '{ROW_CFG,  11'(REG_DIMENSIONS),   3'd0, 16'd15,   1'b0, NoExp},
    '{ROW_CFG,  11'(REG_FIRST_LANDMARK), 3'd0, 16'd1023, 1'b0, NoExp},
    '{ROW_RUN,  11'd0,                 3'd0, 16'h0000, 1'b1, SoleTopPt},
    '{ROW_CFG,  11'(REG_POINT_COUNT),  3'd0, 16'd72,   1'b0, NoExp},
    '{ROW_CFG,  11'(REG_DIMENSIONS),   3'd0, 16'd1,    1'b0, NoExp},
    '{ROW_CFG,  11'(REG_LANDMARK_COUNT), 3'd0, 16'd127, 1'b0, NoExp},
    '{ROW_RUN,  11'd0,                 3'd0, 16'h0000, 1'b0, NoExp}
  };

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic opcode_i = OP_LOAD;
  logic [IdxW-1:0] point_index_i = '0;
  logic [2:0] axis_index_i = '0;
  logic signed [CoordW-1:0] coordinate_i = '0;
  logic cfg_valid_i = 1'b0;
  logic [CfgAW-1:0] cfg_addr_i = '0;
  logic [CfgDW-1:0] cfg_data_i = '0;
  logic busy_o, cfg_ready_o, result_valid_o, last_o;
  logic [IdxW-1:0] landmark_index_o;
  logic [RankW-1:0] rank_o;
  logic [DistW-1:0] min_distance_sq_o;

  farthest_point_landmark_selection_top DUT (.*);

  always #5 clk_i = ~clk_i;

  logic signed [CoordW-1:0] coord_mem [DefMaxPoints][DefMaxDim];
  logic [DistW-1:0] nearest_sq [DefMaxPoints];
  logic chosen [DefMaxPoints];
  logic [10:0] sh_points;
  logic [3:0]  sh_dims;
  logic [6:0]  sh_landmarks;
  logic [9:0]  sh_first;
  landmark_t pending_landmarks [$];
  int mismatches = 0;
  bit idle_on = 1'b1;

  task automatic select_landmarks();
    int n, dims, cnt, cur, best;
    longint best_d, sum, diff;
    n = (sh_points == 0) ? 1 : (sh_points > DefMaxPoints) ? DefMaxPoints : int'(sh_points);
    dims = (sh_dims == 0) ? 1 : (sh_dims > DefMaxDim) ? DefMaxDim : int'(sh_dims);
    cnt = (sh_landmarks == 0) ? 1 :
          (sh_landmarks > DefMaxLandmarks) ? DefMaxLandmarks : int'(sh_landmarks);
    if (cnt > n) cnt = n;
    cur = (sh_first >= n) ? n - 1 : int'(sh_first);
    for (int j = 0; j < DefMaxPoints; j++) begin
      nearest_sq[j] = DistMax;
      chosen[j] = 1'b0;
    end
    chosen[cur] = 1'b1;
    pending_landmarks.push_back('{idx: IdxW'(cur), rank: '0, dist_sq: '0, last: (cnt == 1)});
    for (int r = 1; r < cnt; r++) begin
      best = -1;
      best_d = 0;
      for (int j = 0; j < n; j++) begin
        if (!chosen[j]) begin
          sum = 0;
          for (int a = 0; a < dims; a++) begin
            diff = longint'(coord_mem[cur][a]) - longint'(coord_mem[j][a]);
            sum += diff * diff;
            if (sum > longint'(DistMax)) sum = longint'(DistMax);
          end
          if (sum < longint'(nearest_sq[j])) nearest_sq[j] = sum[DistW-1:0];
          if (best < 0 || longint'(nearest_sq[j]) > best_d) begin
            best = j;
            best_d = longint'(nearest_sq[j]);
          end
        end
      end
      cur = best;
      chosen[cur] = 1'b1;
      pending_landmarks.push_back('{idx: IdxW'(cur), rank: RankW'(r),
                                    dist_sq: best_d[DistW-1:0], last: (r + 1 == cnt)});
    end
  endtask

  task automatic send_request(logic op, logic [IdxW-1:0] pt, logic [2:0] ax,
                              logic [15:0] co, bit typed, landmark_t tv);
    while (idle_on && $urandom_range(99) < 25) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i <= 1'b1;
    opcode_i <= op;
    point_index_i <= pt;
    axis_index_i <= ax;
    coordinate_i <= co;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    if (op == OP_LOAD) coord_mem[pt][ax] = co;
    else if (typed) pending_landmarks.push_back(tv);
    else select_landmarks();
  endtask

  task automatic write_reg(logic [CfgAW-1:0] addr, logic [CfgDW-1:0] data);
    while (idle_on && $urandom_range(99) < 25) begin
      cfg_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    cfg_valid_i <= 1'b1;
    cfg_addr_i <= addr;
    cfg_data_i <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (addr)
      REG_POINT_COUNT:    sh_points = data;
      REG_DIMENSIONS:     sh_dims = data[3:0];
      REG_LANDMARK_COUNT: sh_landmarks = data[6:0];
      REG_FIRST_LANDMARK: sh_first = data[9:0];
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    start_i <= 1'b0;
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_landmarks.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      if (pending_landmarks.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result idx=%0d rank=%0d", landmark_index_o,
                                       rank_o);
      end else begin
        landmark_t e;
        e = pending_landmarks.pop_front();
        if (e.idx !== landmark_index_o || e.rank !== rank_o ||
            e.dist_sq !== min_distance_sq_o || e.last !== last_o) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch exp idx=%0d rank=%0d dist=%0d last=%0d, got %0d %0d %0d %0d",
                     e.idx, e.rank, e.dist_sq, e.last,
                     landmark_index_o, rank_o, min_distance_sq_o, last_o);
        end
      end
    end
  end

  initial begin
    int items;
    int phase;
    int len;
    logic [15:0] co;
    sh_points = 11'd1;
    sh_dims = 4'd1;
    sh_landmarks = 7'd1;
    sh_first = 10'd0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    idle_on = 1'b0;
    for (int p = 0; p < AxisZeroPts; p++)
      for (int a = 0; a < ((p < FullPts) ? DefMaxDim : 1); a++)
        send_request(OP_LOAD, IdxW'(p), 3'(a), 16'($urandom), 1'b0, NoExp);
    idle_on = 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        wait_idle();
        write_reg(dir_rows[i].target[CfgAW-1:0], dir_rows[i].value[CfgDW-1:0]);
      end else begin
        cfg_valid_i <= 1'b0;
        send_request(dir_rows[i].kind == ROW_RUN ? OP_RUN : OP_LOAD,
                     dir_rows[i].target[IdxW-1:0], dir_rows[i].axis,
                     dir_rows[i].value, dir_rows[i].typed, dir_rows[i].exp);
      end
    end

    items = 0;
    phase = 0;
    while (items < 250) begin
      idle_on = !(phase >= 8 && phase < 14);
      wait_idle();
      case ($urandom_range(9))
        0: write_reg(REG_POINT_COUNT, CfgDW'($urandom_range(2047, 1025)));
        1: write_reg(REG_POINT_COUNT, '0);
        default: write_reg(REG_POINT_COUNT, CfgDW'($urandom_range(FullPts, 1)));
      endcase
      write_reg(REG_DIMENSIONS, CfgDW'($urandom_range(15)));
      write_reg(REG_LANDMARK_COUNT, CfgDW'(($urandom_range(3) == 0) ? $urandom_range(127) :
                                           $urandom_range(24)));
      write_reg(REG_FIRST_LANDMARK, CfgDW'(($urandom_range(3) == 0) ? $urandom_range(1023) :
                                           $urandom_range(30)));
      if (sh_points > FullPts) write_reg(REG_LANDMARK_COUNT, CfgDW'($urandom_range(1)));
      write_reg(CfgAW'($urandom_range(7)), CfgDW'($urandom));
      if (sh_points > FullPts && sh_landmarks > 1) write_reg(REG_LANDMARK_COUNT, CfgDW'(1));
      cfg_valid_i <= 1'b0;
      len = $urandom_range(30, 10);
      for (int k = 0; k < len; k++) begin
        co = ($urandom_range(9) < 3) ? 16'($signed($urandom_range(4)) - 2) : 16'($urandom);
        if ($urandom_range(99) < 20)
          send_request(OP_RUN, 10'($urandom), 3'($urandom), 16'($urandom), 1'b0, NoExp);
        else
          send_request(OP_LOAD, ($urandom_range(3) == 0) ? 10'($urandom) :
                       10'($urandom_range(FullPts - 1)), 3'($urandom), co, 1'b0, NoExp);
        items++;
      end
      phase++;
    end

    wait_idle();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && pending_landmarks.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("FAILURE");
    $finish;
  end
endmodule
